// ===== hw/rtl/nts_pkg.sv =====
// ----------------------------------------------------------------------------
// nts_pkg: shared types and constants for the melody sequencer
// Field widths, item kinds, register indexes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package nts_pkg;

  // Table geometry
  localparam int MAX_NOTES = 64;
  localparam int IDX_W     = $clog2(MAX_NOTES);
  localparam int COUNT_W   = IDX_W + 1;

  // Field widths
  localparam int PITCH_W   = 16;
  localparam int DIVR_W    = 8;
  localparam int WHOLE_W   = 16;
  localparam int DUR_W     = 17;
  localparam int ENTRY_W   = PITCH_W + DIVR_W;
  localparam int NINE_W    = DUR_W + 3;

  // Serial divider: one quotient bit per cycle over the whole-note dividend
  localparam int DIV_CNT_W = $clog2(WHOLE_W);

  // floor(y / 10) == (y * RECIP_TEN) >> RECIP_SHIFT for every y below 2^22
  localparam int RECIP_SHIFT = 23;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP_TEN = 24'd838861;
  localparam int PROD_W      = NINE_W + RECIP_W;

  localparam logic [DUR_W-1:0] ELAPSED_MAX = {DUR_W{1'b1}};

  // Stream payload widths
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;
  localparam int FUNC_W     = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_NOTE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MELODY_LEN = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_READ,
    ST_DIVIDE,
    ST_SCALE,
    ST_NINE,
    ST_GATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic latch;      // capture the accepted request
    logic ram_read;   // read the current note entry
    logic div_start;  // launch whole / |divider|
    logic scale;      // form note length
    logic nine;       // form 9 * length
    logic gate;       // form floor(9 * length / 10)
    logic commit;     // update state and load the result register
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  note_ok;   // tick would evaluate a note
    logic  div_busy;
    logic  slot_free; // result register can take a new result
  } status_t;

endpackage

// ===== hw/rtl/nts_ram.sv =====
// ----------------------------------------------------------------------------
// nts_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/nts_div.sv =====
// ----------------------------------------------------------------------------
// nts_div: serial restoring divider
// Divides the whole-note time by the divider magnitude, one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module nts_div
  import nts_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [WHOLE_W-1:0] dividend,
  input  logic [DIVR_W-1:0]  divisor,
  output logic               busy,
  output logic [WHOLE_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVR_W-1:0]    rem_r, rem_nxt;
  logic [WHOLE_W-1:0]   quo_r, quo_nxt;
  logic [DIVR_W-1:0]    dsr_r, dsr_nxt;
  logic [DIVR_W:0]      trial;
  logic                 fits;

  // One trial subtraction per cycle
  always_comb begin
    trial    = {rem_r, quo_r[WHOLE_W-1]};
    fits     = trial >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? DIVR_W'(trial - {1'b0, dsr_r}) : trial[DIVR_W-1:0];
      quo_nxt = {quo_r[WHOLE_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(WHOLE_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/nts_ctrl.sv =====
// ----------------------------------------------------------------------------
// nts_ctrl: sequencer controller
// Steps each request through dispatch and result commit; a tick that
// evaluates a note also passes table read, divide and scaling.
// ----------------------------------------------------------------------------
module nts_ctrl
  import nts_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (status.func == FUNC_TICK && status.note_ok) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ:   state_nxt = ST_DIVIDE;
      ST_DIVIDE: begin
        if (!status.div_busy) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE:  state_nxt = ST_NINE;
      ST_NINE:   state_nxt = ST_GATE;
      ST_GATE:   state_nxt = ST_DONE;
      ST_DONE: begin
        if (status.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd           = '0;
    in_ready      = (state_r == ST_IDLE);
    cmd.latch     = (state_r == ST_IDLE) && in_valid;
    cmd.ram_read  = (state_r == ST_DISPATCH);
    cmd.div_start = (state_r == ST_READ);
    cmd.scale     = (state_r == ST_SCALE);
    cmd.nine      = (state_r == ST_NINE);
    cmd.gate      = (state_r == ST_GATE);
    cmd.commit    = (state_r == ST_DONE) && status.slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/nts_dp.sv =====
// ----------------------------------------------------------------------------
// nts_dp: sequencer datapath
// Holds configuration, playback state, the note table, the note length
// arithmetic and the result register.
// ----------------------------------------------------------------------------
module nts_dp
  import nts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [IDX_W-1:0]      in_index,
  input  logic [PITCH_W-1:0]    in_pitch,
  input  logic [DIVR_W-1:0]     in_divider,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_tone_start,
  output logic [PITCH_W-1:0]    out_pitch,
  output logic [DUR_W-1:0]      out_gate,
  output logic                  out_sounding,
  output logic                  out_playing,
  output logic [COUNT_W-1:0]    out_note_index
);

  // Configuration
  logic [WHOLE_W-1:0] whole_r;
  logic [COUNT_W-1:0] mlen_r;

  // Playback state
  logic [COUNT_W-1:0] cur_r, cur_nxt;
  logic [DUR_W-1:0]   elapsed_r, elapsed_nxt;
  logic               playing_r, playing_nxt;
  logic               begun_r, begun_nxt;

  // Latched request
  func_t              func_r;
  logic [IDX_W-1:0]   idx_r;
  logic [PITCH_W-1:0] pitch_r;
  logic [DIVR_W-1:0]  divr_r;

  // Arithmetic
  logic [ENTRY_W-1:0] entry;
  logic [DIVR_W-1:0]  entry_div;
  logic [DIVR_W-1:0]  mag;
  logic [WHOLE_W-1:0] quo;
  logic               div_busy;
  logic [DUR_W-1:0]   dur_r;
  logic [NINE_W-1:0]  nine_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DUR_W-1:0]   gate;

  // Result register
  logic               oval_r, oval_nxt;
  logic               o_start_r, o_start_nxt;
  logic [PITCH_W-1:0] o_pitch_r, o_pitch_nxt;
  logic [DUR_W-1:0]   o_gate_r, o_gate_nxt;
  logic               o_snd_r, o_snd_nxt;
  logic               o_play_r, o_play_nxt;
  logic [COUNT_W-1:0] o_idx_r, o_idx_nxt;

  logic [COUNT_W-1:0] len_eff;
  logic [DUR_W-1:0]   elapsed_inc;
  logic               slot_free;
  logic               note_ok;

  // Note table
  nts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_NOTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.commit && func_r == FUNC_WRITE),
    .waddr (idx_r),
    .wdata ({pitch_r, divr_r}),
    .re    (cmd.ram_read),
    .raddr (cur_r[IDX_W-1:0]),
    .rdata (entry)
  );

  assign entry_div = entry[DIVR_W-1:0];
  assign mag       = entry_div[DIVR_W-1] ? DIVR_W'(-entry_div) : entry_div;

  nts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (whole_r),
    .divisor  (mag),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign gate = prod_r[RECIP_SHIFT +: DUR_W];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      whole_r <= WHOLE_W'(2000);
      mlen_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHOLE_NOTE: whole_r <= cfg_wdata;
        CFG_MELODY_LEN: mlen_r  <= cfg_wdata[COUNT_W-1:0];
        default:        ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r  <= func_t'(in_func);
      idx_r   <= in_index;
      pitch_r <= in_pitch;
      divr_r  <= in_divider;
    end
  end

  // Length, 9 * length, and the reciprocal product
  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      if (mag == '0) begin
        dur_r <= '0;
      end else if (entry_div[DIVR_W-1]) begin
        dur_r <= DUR_W'(quo) + DUR_W'(quo >> 1);
      end else begin
        dur_r <= DUR_W'(quo);
      end
    end
    if (cmd.nine) begin
      nine_r <= {dur_r, 3'b000} + NINE_W'(dur_r);
    end
    if (cmd.gate) begin
      prod_r <= PROD_W'(nine_r) * PROD_W'(RECIP_TEN);
    end
  end

  assign len_eff     = (mlen_r > COUNT_W'(MAX_NOTES)) ? COUNT_W'(MAX_NOTES) : mlen_r;
  assign note_ok     = playing_r && (len_eff != '0) && (cur_r < len_eff);
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign slot_free   = !oval_r || out_ready;

  // Resolve the request and form the result
  always_comb begin
    cur_nxt     = cur_r;
    elapsed_nxt = elapsed_r;
    playing_nxt = playing_r;
    begun_nxt   = begun_r;
    o_start_nxt = 1'b0;
    o_pitch_nxt = '0;
    o_gate_nxt  = '0;
    o_snd_nxt   = 1'b0;
    o_idx_nxt   = cur_r;
    unique case (func_r)
      FUNC_START: begin
        cur_nxt     = '0;
        elapsed_nxt = '0;
        playing_nxt = 1'b1;
        begun_nxt   = 1'b0;
        o_idx_nxt   = '0;
      end
      FUNC_TICK: begin
        if (playing_r && !note_ok) begin
          playing_nxt = 1'b0;
        end else if (note_ok) begin
          o_pitch_nxt = entry[ENTRY_W-1:DIVR_W];
          o_gate_nxt  = gate;
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= dur_r) begin
            // advance to the next note, stop after the last one
            cur_nxt     = cur_r + 1'b1;
            elapsed_nxt = '0;
            begun_nxt   = 1'b0;
            if (cur_r + 1'b1 >= len_eff) begin
              playing_nxt = 1'b0;
            end
          end else if (elapsed_inc <= gate) begin
            o_snd_nxt = 1'b1;
            if (!begun_r) begin
              o_start_nxt = 1'b1;
              begun_nxt   = 1'b1;
            end
          end
        end
      end
      FUNC_WRITE, FUNC_NONE: ;
      default: ;
    endcase
    o_play_nxt = playing_nxt;
    oval_nxt   = cmd.commit ? 1'b1 : (out_ready ? 1'b0 : oval_r);
  end

  // Playback state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      elapsed_r <= '0;
      playing_r <= 1'b0;
      begun_r   <= 1'b0;
      oval_r    <= 1'b0;
    end else begin
      oval_r <= oval_nxt;
      if (cmd.commit) begin
        cur_r     <= cur_nxt;
        elapsed_r <= elapsed_nxt;
        playing_r <= playing_nxt;
        begun_r   <= begun_nxt;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      o_start_r <= o_start_nxt;
      o_pitch_r <= o_pitch_nxt;
      o_gate_r  <= o_gate_nxt;
      o_snd_r   <= o_snd_nxt;
      o_play_r  <= o_play_nxt;
      o_idx_r   <= o_idx_nxt;
    end
  end

  assign status.func      = func_r;
  assign status.note_ok   = note_ok;
  assign status.div_busy  = div_busy;
  assign status.slot_free = slot_free;

  assign out_valid      = oval_r;
  assign out_tone_start = o_start_r;
  assign out_pitch      = o_pitch_r;
  assign out_gate       = o_gate_r;
  assign out_sounding   = o_snd_r;
  assign out_playing    = o_play_r;
  assign out_note_index = o_idx_r;

endmodule

// ===== hw/rtl/note_table_melody_sequencer.sv =====
// ----------------------------------------------------------------------------
// note_table_melody_sequencer: melody sequencer over a stored note table
// Table writes, playback start and millisecond ticks in; one result per
// request out.
// ----------------------------------------------------------------------------
// Takes one request at a time and returns exactly one result for each. A
// tick that evaluates a note goes through a table read, a serial divide of the
// whole-note time by the divider magnitude, and three arithmetic stages for
// the dotted-note scaling and the 90 percent gate before the next request
// can be taken; every other request goes from dispatch straight to commit.
// The result sits in an output register, so a tick is accepted and worked
// on while the previous result still waits; the commit stalls only until
// that register frees up. Table entries have no reset and must be written
// before they are played.
module note_table_melody_sequencer
  import nts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // entry_index [5:0], entry_pitch [21:6], entry_divider [29:22], zero [31:30]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func [1:0]
  input  logic [FUNC_W-1:0]     in_tuser,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tone_start [0], pitch_hz [16:1], gate_ms [33:17], sounding [34],
  // playing [35], note_index [42:36], zero [47:43]
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t               cmd;
  status_t            status;
  logic               o_start;
  logic [PITCH_W-1:0] o_pitch;
  logic [DUR_W-1:0]   o_gate;
  logic               o_snd;
  logic               o_play;
  logic [COUNT_W-1:0] o_idx;

  nts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  nts_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_func        (in_tuser),
    .in_index       (in_tdata[IDX_W-1:0]),
    .in_pitch       (in_tdata[IDX_W +: PITCH_W]),
    .in_divider     (in_tdata[IDX_W+PITCH_W +: DIVR_W]),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_tone_start (o_start),
    .out_pitch      (o_pitch),
    .out_gate       (o_gate),
    .out_sounding   (o_snd),
    .out_playing    (o_play),
    .out_note_index (o_idx)
  );

  // Pack the result
  assign out_tdata = {5'b0, o_idx, o_play, o_snd, o_gate, o_pitch, o_start};

  // One request in flight: no new request right after an acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while another is in flight");

  // A tone start is always a sounding note of a running melody
  a_start_sounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_start) |-> (o_snd && o_play))
    else $error("tone start without sounding playback");

  // A sounding note has a nonzero gate
  a_gate_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && o_snd) |-> (o_gate != '0))
    else $error("sounding with zero gate");

  // The result register fills only while the controller is busy
  a_fill_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !in_tready)
    else $error("result committed while idle");

endmodule

// ===== tb/melody_check_pkg.sv =====
// ----------------------------------------------------------------------------
// melody_check_pkg: tone predictor and result checker for the sequencer bench
// Tracks the note table, the play position and the tempo registers, works
// out the result of every accepted request and compares arriving results
// against them in order.
// ----------------------------------------------------------------------------
package melody_check_pkg;
  import nts_pkg::*;

  // Result layout, lowest bit last
  typedef struct packed {
    logic [4:0]  pad;
    logic [6:0]  note_index;
    logic        playing;
    logic        sounding;
    logic [16:0] gate_ms;
    logic [15:0] pitch_hz;
    logic        tone_start;
  } tone_result_t;

  class melody_tracker;
    logic [23:0]  score_table [MAX_NOTES];
    logic [6:0]   note_pos;
    logic [16:0]  ms_count;
    logic         active;
    logic         onset_done;
    logic [15:0]  whole_ms;
    logic [6:0]   tune_len;
    tone_result_t tone_queue [$];
    int           mismatch_count;

    function new();
      foreach (score_table[i]) score_table[i] = '0;
      note_pos       = '0;
      ms_count       = '0;
      active         = 1'b0;
      onset_done     = 1'b0;
      whole_ms       = 16'd2000;
      tune_len       = '0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_WHOLE_NOTE: whole_ms = value[15:0];
        CFG_MELODY_LEN: tune_len = value[6:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return tone_queue.size();
    endfunction

    // Note length in ms: whole / |divider|, dotted notes add half again
    function logic [16:0] beat_length(logic signed [7:0] divr);
      logic [7:0]  mag;
      logic [16:0] q;
      if (divr == 0) return '0;
      mag = divr[7] ? -divr : divr;
      q = 17'(whole_ms) / 17'(mag);
      if (divr[7]) q = q + (q >> 1);
      return q;
    endfunction

    // Advance the predicted state by one accepted request, queue its result
    function void take_request(func_t kind, logic [5:0] idx, logic [15:0] pitch,
                               logic [7:0] divr);
      tone_result_t r;
      logic [6:0]   eff;
      logic [23:0]  entry;
      logic [16:0]  dur;
      logic [16:0]  gate;
      logic [19:0]  nine;
      r = '0;
      r.note_index = note_pos;
      case (kind)
        FUNC_WRITE: score_table[idx] = {pitch, divr};
        FUNC_START: begin
          note_pos     = '0;
          ms_count     = '0;
          active       = 1'b1;
          onset_done   = 1'b0;
          r.note_index = '0;
        end
        FUNC_TICK: if (active) begin
          eff = (tune_len < 7'(MAX_NOTES)) ? tune_len : 7'(MAX_NOTES);
          // stop when the melody is empty or ends under the play position
          if (eff == 0 || note_pos >= eff) begin
            active = 1'b0;
          end else begin
            entry        = score_table[note_pos[5:0]];
            dur          = beat_length(entry[7:0]);
            nine         = 20'(dur) * 20'd9;
            gate         = 17'(nine / 20'd10);
            r.pitch_hz   = entry[23:8];
            r.gate_ms    = gate;
            r.note_index = note_pos;
            if (ms_count != ELAPSED_MAX) ms_count = ms_count + 1'b1;
            if (ms_count >= dur) begin
              note_pos   = note_pos + 1'b1;
              if (note_pos >= eff) active = 1'b0;
              ms_count   = '0;
              onset_done = 1'b0;
            end else if (ms_count <= gate) begin
              r.sounding = 1'b1;
              if (!onset_done) begin
                r.tone_start = 1'b1;
                onset_done   = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      r.playing = active;
      tone_queue.push_back(r);
    endfunction

    function void compare_field(string name, logic [16:0] want, logic [16:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatch_count++;
      end
    endfunction

    // Match one arriving result against the oldest prediction
    function void check_result(logic [OUT_DATA_W-1:0] data);
      tone_result_t got;
      tone_result_t want;
      got = data;
      if (tone_queue.size() == 0) begin
        $error("result %h arrived with no request pending", data);
        mismatch_count++;
        return;
      end
      want = tone_queue.pop_front();
      compare_field("tone_start", 17'(want.tone_start), 17'(got.tone_start));
      compare_field("pitch_hz", 17'(want.pitch_hz), 17'(got.pitch_hz));
      compare_field("gate_ms", want.gate_ms, got.gate_ms);
      compare_field("sounding", 17'(want.sounding), 17'(got.sounding));
      compare_field("playing", 17'(want.playing), 17'(got.playing));
      compare_field("note_index", 17'(want.note_index), 17'(got.note_index));
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: stream bench for the note table melody sequencer
// Fills the note table, runs directed melodies over the tempo extremes, then
// random phases of ticks, starts and table writes with random gaps on both
// sides, checking every result against the tone predictor.
// ----------------------------------------------------------------------------
module tb_top;
  import nts_pkg::*;
  import melody_check_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [FUNC_W-1:0]     in_tuser   = FUNC_NONE;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_WHOLE_NOTE;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  logic          in_quiet  = 1'b0;
  logic          out_quiet = 1'b0;
  int            results_taken = 0;
  melody_tracker sb;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  note_table_melody_sequencer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic int draw_gap(logic quiet);
    return quiet ? 0 : int'($urandom_range(0, 17));
  endfunction

  // Offer one request after a random gap, hold it until accepted
  task automatic send_request(func_t kind, logic [5:0] idx, logic [15:0] pitch,
                              logic [7:0] divr);
    int gap;
    gap = draw_gap(in_quiet);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= {2'b00, divr, pitch, idx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tready === 1'b1));
    sb.take_request(kind, idx, pitch, divr);
  endtask

  // Request of any kind with random payload bits
  task automatic send_noise(func_t kind);
    send_request(kind, 6'($urandom_range(0, 63)), 16'($urandom()), 8'($urandom()));
  endtask

  task automatic send_random_write(logic [5:0] idx);
    int          d;
    logic [15:0] pitch;
    case ($urandom_range(0, 7))
      0: pitch = '0;
      1: pitch = '1;
      default: pitch = 16'($urandom_range(0, 65535));
    endcase
    // favor short dividers so notes are long enough to sound
    if ($urandom_range(0, 1) == 1) d = int'($urandom_range(0, 16)) - 8;
    else d = int'($urandom_range(0, 128)) - 64;
    send_request(FUNC_WRITE, idx, pitch, 8'(d));
  endtask

  // Write both registers; call only with no request in flight
  task automatic set_tempo(logic [15:0] whole, logic [6:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WHOLE_NOTE;
    cfg_wdata <= whole;
    @(posedge clk);
    cfg_index <= CFG_MELODY_LEN;
    cfg_wdata <= 16'(len);
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_register(CFG_WHOLE_NOTE, whole);
    sb.set_register(CFG_MELODY_LEN, 16'(len));
    @(posedge clk);
  endtask

  // Hold off the input until every predicted result has come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // Mostly ticks while playing, mostly starts while stopped
  task automatic random_phase(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (sb.active) begin
        if (roll < 80) send_noise(FUNC_TICK);
        else if (roll < 85) send_noise(FUNC_START);
        else if (roll < 97) send_random_write(6'($urandom_range(0, 63)));
        else send_noise(FUNC_NONE);
      end else begin
        if (roll < 60) send_noise(FUNC_START);
        else if (roll < 75) send_noise(FUNC_TICK);
        else if (roll < 95) send_random_write(6'($urandom_range(0, 63)));
        else send_noise(FUNC_NONE);
      end
    end
  endtask

  // Result side: random stall per result, one long hold to back up the input
  initial begin : result_sink
    int gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = (results_taken == 700) ? 500 : draw_gap(out_quiet);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && out_tready));
      sb.check_result(out_tdata);
      results_taken++;
    end
  end

  initial begin : stimulus
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset tempo, empty melody: idle tick, start, tick that stops at once
    send_request(FUNC_TICK, '0, '0, '0);
    send_request(FUNC_START, '1, '1, '1);
    send_request(FUNC_TICK, '0, '0, '0);

    // fill every slot so playback never reads an unwritten entry
    for (int i = 0; i < MAX_NOTES; i++) send_random_write(6'(i));

    // plain note, dotted rest, zero divider, dividers of plus and minus 64
    send_request(FUNC_WRITE, 6'd0, 16'hFFFF, 8'h04);
    send_request(FUNC_WRITE, 6'd1, 16'h0000, 8'hFE);
    send_request(FUNC_WRITE, 6'd2, 16'd1234, 8'h00);
    send_request(FUNC_WRITE, 6'd62, 16'd440, 8'h40);
    send_request(FUNC_WRITE, 6'd63, 16'd1, 8'hC0);
    drain_results();
    set_tempo(16'd8, 7'd3);
    send_request(FUNC_START, '0, '0, '0);
    repeat (10) send_request(FUNC_TICK, '1, '1, '1);
    send_request(FUNC_NONE, '1, '1, '1);

    // longest dotted note gives the widest gate
    send_request(FUNC_WRITE, 6'd0, 16'hFFFF, 8'hFF);
    drain_results();
    set_tempo(16'hFFFF, 7'd1);
    send_request(FUNC_START, '0, '0, '0);
    repeat (2) send_request(FUNC_TICK, '0, '0, '0);

    // zero whole note, then shorten the melody under the play position
    drain_results();
    set_tempo(16'd0, 7'd64);
    send_request(FUNC_START, '0, '0, '0);
    repeat (2) send_request(FUNC_TICK, '0, '0, '0);
    drain_results();
    set_tempo(16'd0, 7'd1);
    repeat (2) send_request(FUNC_TICK, '0, '0, '0);
    drain_results();

    // random phases over several tempo and length settings
    for (int p = 0; p < 10; p++) begin
      in_quiet  = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      case (p)
        0: set_tempo(16'd1, 7'd64);
        1: set_tempo(16'hFFFF, 7'd4);
        2: set_tempo(16'd0, 7'd10);
        3: set_tempo(16'd2000, 7'd64);
        4: set_tempo(16'($urandom_range(1, 40)), 7'd127);
        7: set_tempo(16'($urandom_range(1, 96)), 7'd0);
        default: set_tempo(16'($urandom_range(1, 96)), 7'($urandom_range(1, 64)));
      endcase
      if (p == 5) begin
        random_phase(90);
        drain_results();
        random_phase(85);
      end else begin
        random_phase(175);
      end
      drain_results();
    end

    repeat (40) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
